// ===== design/qbs_pkg.sv =====
// Shared types and constants for the quadratic Bezier sampler.
// No dependencies; imported by every module of the block.
package qbs_pkg;

   localparam int CW          = 24;                  // coordinate width, signed Q7.16
   localparam int MAX_SAMPLES = 64;
   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int SEG_W       = 6;
   localparam int STEP_W      = 16;
   localparam int T_W         = 17;                  // t in unsigned Q1.16
   localparam logic [T_W-1:0] ONE_T = T_W'(65536);

   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_T_STEP   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENTS = CSR_IDX_W'(1);

   localparam logic [STEP_W-1:0] T_STEP_RST   = STEP_W'(13107);
   localparam logic [SEG_W-1:0]  SEGMENTS_RST = SEG_W'(5);

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic [STEP_W-1:0] t_step;
      logic [SEG_W-1:0]  segments;
   } qbs_cfg_type;

   // One curve: anchor (a), middle (b) and end point (c).
   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type cx;
      coord_type cy;
   } qbs_job_type;

endpackage

// ===== design/qbs_front.sv =====
// Front end: takes control points, tracks pairing and issues complete triples.
// Depends on qbs_pkg.
module qbs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  qbs_pkg::coord_type  point_x,
   input  qbs_pkg::coord_type  point_y,
   input  logic                start_req,
   output logic                job_valid,
   input  logic                job_ready,
   output qbs_pkg::qbs_job_type job
);
   import qbs_pkg::*;

   typedef enum logic [2:0] {
      PH_EMPTY  = 3'b001,
      PH_ANCHOR = 3'b010,
      PH_MIDDLE = 3'b100
   } phase_type;

   phase_type phase_ff, phase_in;
   coord_type anchor_x_ff, anchor_y_ff, middle_x_ff, middle_y_ff;
   logic      accept;
   logic      completes;

   // stall only on queue space so the handshake does not depend on the payload
   assign req_tready = job_ready;
   assign accept     = req_tvalid && req_tready;
   assign completes  = accept && !start_req && (phase_ff == PH_MIDDLE);

   assign job_valid = completes;
   assign job.ax    = anchor_x_ff;
   assign job.ay    = anchor_y_ff;
   assign job.bx    = middle_x_ff;
   assign job.by    = middle_y_ff;
   assign job.cx    = point_x;
   assign job.cy    = point_y;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (start_req) begin
            phase_in = PH_ANCHOR;
         end else begin
            case (phase_ff)
               PH_EMPTY:  phase_in = PH_ANCHOR;
               PH_ANCHOR: phase_in = PH_MIDDLE;
               PH_MIDDLE: phase_in = PH_ANCHOR;
               default:   phase_in = PH_ANCHOR;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_EMPTY;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // the end point of a curve is the anchor of the next one
   always_ff @(posedge clock) begin
      if (accept) begin
         if (phase_ff == PH_ANCHOR && !start_req) begin
            middle_x_ff <= point_x;
            middle_y_ff <= point_y;
         end else begin
            anchor_x_ff <= point_x;
            anchor_y_ff <= point_y;
         end
      end
   end

endmodule

// ===== design/qbs_queue.sv =====
// Two-entry queue of curve jobs between the front end and the evaluator.
// Depends on qbs_pkg. Head always sits in slot 0.
module qbs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  qbs_pkg::qbs_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output qbs_pkg::qbs_job_type pop_job
);
   import qbs_pkg::*;

   qbs_job_type slot0_ff, slot1_ff;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = slot0_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (push && count_ff == 2'd1) begin
            slot0_ff <= push_job;
         end else begin
            slot0_ff <= slot1_ff;
         end
         if (push && count_ff == 2'd2) begin
            slot1_ff <= push_job;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_ff <= push_job;
         end else begin
            slot1_ff <= push_job;
         end
      end
   end

endmodule

// ===== design/qbs_eval.sv =====
// Back end: steps t over one curve and evaluates a + 2t(b-a) + t^2(a-2b+c).
// Depends on qbs_pkg. Four register stages from issue to the output register.
module qbs_eval (
   input  logic                 clock,
   input  logic                 reset,
   input  qbs_pkg::qbs_cfg_type cfg,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  qbs_pkg::qbs_job_type job,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output qbs_pkg::coord_type   curve_x,
   output qbs_pkg::coord_type   curve_y,
   output logic                 rsp_tlast
);
   import qbs_pkg::*;

   localparam int D1_W = CW + 1;
   localparam int D2_W = CW + 2;
   localparam int TT_W = 2 * T_W;
   localparam int P1_W = T_W + 1 + D1_W;
   localparam int SW   = TT_W + 1 + D2_W;
   localparam int HI_W = SW - 32;
   localparam logic signed [SW-1:0] RND = SW'(64'h8000_0000);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   coord_type                ax_ff, ay_ff;
   logic signed [D1_W-1:0]   d1x_ff, d1y_ff;
   logic signed [D2_W-1:0]   d2x_ff, d2y_ff;
   logic [T_W-1:0]           t_ff, t_in;
   logic [IDX_W-1:0]         idx_ff, last_idx_ff;
   logic [T_W:0]             t_sum;

   logic                     v1_ff, v2_ff, v3_ff;
   logic                     l1_ff, l2_ff, l3_ff;
   logic [TT_W-1:0]          tt1_ff;
   logic signed [P1_W-1:0]   p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic signed [SW-1:0]     q2x_ff, q2y_ff, sx_ff, sy_ff;

   logic                     adv, issue, issue_last, pop;
   logic signed [T_W:0]      t_sg;
   logic signed [TT_W:0]     tt_sg;
   logic signed [HI_W-1:0]   hx, hy;
   logic [IDX_W:0]           seg_ext;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign issue      = (state_ff == ST_RUN) && adv;
   assign issue_last = (idx_ff == last_idx_ff);
   // a new curve loads only after the last one drained, since a is used late
   assign pop        = (state_ff == ST_IDLE) && job_valid && !v1_ff && !v2_ff && !v3_ff;
   assign job_ready  = pop;

   assign t_sum   = {1'b0, t_ff} + (T_W + 1)'(cfg.t_step);
   assign t_in    = (t_sum > (T_W + 1)'(ONE_T)) ? ONE_T : t_sum[T_W-1:0];
   assign seg_ext = (IDX_W + 1)'(cfg.segments);
   assign t_sg    = $signed({1'b0, t_ff});
   assign tt_sg   = $signed({1'b0, tt1_ff});
   assign hx      = sx_ff[SW-1:32];
   assign hy      = sy_ff[SW-1:32];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (pop) state_in = ST_RUN;
         ST_RUN:  if (issue && issue_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (adv) begin
            v1_ff      <= issue;
            v2_ff      <= v1_ff;
            v3_ff      <= v2_ff;
            rsp_tvalid <= v3_ff;
         end
      end
   end

   // curve setup
   always_ff @(posedge clock) begin
      if (pop) begin
         ax_ff  <= job.ax;
         ay_ff  <= job.ay;
         d1x_ff <= D1_W'(job.bx) - D1_W'(job.ax);
         d1y_ff <= D1_W'(job.by) - D1_W'(job.ay);
         d2x_ff <= D2_W'(job.ax) - (D2_W'(job.bx) <<< 1) + D2_W'(job.cx);
         d2y_ff <= D2_W'(job.ay) - (D2_W'(job.by) <<< 1) + D2_W'(job.cy);
         t_ff   <= '0;
         idx_ff <= '0;
         if (seg_ext > (IDX_W + 1)'(MAX_SAMPLES - 1)) begin
            last_idx_ff <= IDX_W'(MAX_SAMPLES - 1);
         end else begin
            last_idx_ff <= cfg.segments[IDX_W-1:0];
         end
      end else if (issue) begin
         t_ff   <= t_in;
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // datapath; all stages move together on adv
   always_ff @(posedge clock) begin
      if (adv) begin
         tt1_ff    <= TT_W'(t_ff) * TT_W'(t_ff);
         p1x_ff    <= P1_W'(t_sg) * P1_W'(d1x_ff);
         p1y_ff    <= P1_W'(t_sg) * P1_W'(d1y_ff);
         l1_ff     <= issue_last;

         q2x_ff    <= SW'(tt_sg) * SW'(d2x_ff);
         q2y_ff    <= SW'(tt_sg) * SW'(d2y_ff);
         p2x_ff    <= p1x_ff;
         p2y_ff    <= p1y_ff;
         l2_ff     <= l1_ff;

         sx_ff     <= (SW'(p2x_ff) <<< 17) + q2x_ff + RND;
         sy_ff     <= (SW'(p2y_ff) <<< 17) + q2y_ff + RND;
         l3_ff     <= l2_ff;

         curve_x   <= CW'(hx + HI_W'(ax_ff));
         curve_y   <= CW'(hy + HI_W'(ay_ff));
         rsp_tlast <= l3_ff;
      end
   end

   a_t_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (t_ff <= ONE_T))
      else $error("t above one while sampling");

   a_pop_drained: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!v1_ff && !v2_ff && !v3_ff))
      else $error("curve loaded with samples in flight");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (issue && issue_last) |=> (state_ff == ST_IDLE))
      else $error("sampling continued past last sample");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (idx_ff <= last_idx_ff))
      else $error("sample index past end of curve");

endmodule

// ===== design/quadratic_bezier_sampler.sv =====
// Top level of the quadratic Bezier sampler: config registers and the
// front end / job queue / evaluator chain. Depends on qbs_pkg and its modules.
//
//  channel  dir  payload (low bit first)                  handshake
//  req_     in   tdata: point_x, point_y; tuser: start    tvalid/tready
//  rsp_     out  tdata: curve_x, curve_y; tlast: last     tvalid/tready
//  csr_     in   index 0 t_step, 1 segments; wdata        valid/ready
//
// A point is taken each cycle while the job queue has room; the third point
// of a run and every second point after it complete a curve. A curve holds the
// evaluator while it loads, while it issues segments+1 samples, one per cycle
// unless the output stalls, and until its four-stage pipeline has drained.
// Reset is synchronous; nothing needs clearing after it. An output stall
// freezes the whole evaluator pipeline.
module quadratic_bezier_sampler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [47:0]                     req_tdata,   // point_x, point_y
   input  logic                            req_tuser,   // start_req
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [47:0]                     rsp_tdata,   // curve_x, curve_y
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import qbs_pkg::*;

   qbs_cfg_type cfg_ff;
   qbs_job_type front_job, queue_job;
   logic        front_valid, front_ready, queue_valid, queue_ready;
   coord_type   curve_x, curve_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.t_step   <= T_STEP_RST;
         cfg_ff.segments <= SEGMENTS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_T_STEP:   cfg_ff.t_step   <= csr_wdata[STEP_W-1:0];
            CSR_SEGMENTS: cfg_ff.segments <= csr_wdata[SEG_W-1:0];
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   qbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .point_x    (req_tdata[CW-1:0]),
      .point_y    (req_tdata[2*CW-1:CW]),
      .start_req  (req_tuser),
      .job_valid  (front_valid),
      .job_ready  (front_ready),
      .job        (front_job)
   );

   qbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_job    (queue_job)
   );

   qbs_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (queue_valid),
      .job_ready  (queue_ready),
      .job        (queue_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .curve_x    (curve_x),
      .curve_y    (curve_y),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {curve_y, curve_x};

endmodule
